// ===== hw/rtl/soil_moisture_pump_controller_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pump controller RTL.
// ----------------------------------------------------------------------------
`ifndef SOIL_MOISTURE_PUMP_CONTROLLER_TOP_DEFINES_SVH
`define SOIL_MOISTURE_PUMP_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SMPC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/smpc_pkg.sv =====
// ----------------------------------------------------------------------------
// smpc_pkg
// Types, constants and codes shared by the pump controller modules.
// ----------------------------------------------------------------------------
package smpc_pkg;

    localparam int SENSORS = 6;
    localparam int SIDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    localparam int ACT_W   = 2;
    localparam int IDX_W   = 3;
    localparam int RAW_W   = 12;
    localparam int PCT_W   = 7;
    localparam int TIME_W  = 16;
    localparam int RUN_W   = 32;
    localparam int NUM_W   = 19;
    localparam int STEP_W  = 3;
    localparam int CFG_IW  = 2;
    localparam int CFG_W   = 16;

    localparam logic [PCT_W-1:0]  FULL_PERCENT = 7'd100;
    localparam logic [STEP_W-1:0] LAST_STEP    = 3'(PCT_W - 1);

    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MANUAL = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_AIR       = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_WATER     = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_PUMP_TIME = 2'd3;

    localparam logic [RAW_W-1:0]  AIR_RESET       = 12'd3000;
    localparam logic [RAW_W-1:0]  WATER_RESET     = 12'd1200;
    localparam logic [PCT_W-1:0]  THRESHOLD_RESET = 7'd40;
    localparam logic [TIME_W-1:0] PUMP_TIME_RESET = 16'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_EVAL,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] sensor_index;
        logic [RAW_W-1:0] raw_value;
        logic             last_sample;
    } req_t;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic             pump_on;
        logic             green_led;
        logic             red_led;
        logic             pump_started;
        logic             pump_stopped;
        logic [RUN_W-1:0] run_count;
    } rsp_t;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              div;
        logic [STEP_W-1:0] step;
        logic              store;
        logic              eval;
    } dp_cmd_t;

    typedef struct packed {
        logic is_sample;
        logic need_div;
    } dp_status_t;

endpackage

// ===== hw/rtl/smpc_datapath.sv =====
// ----------------------------------------------------------------------------
// smpc_datapath
// Settings, sample conversion with a serial divider, sensor store and pump state.
// ----------------------------------------------------------------------------
`include "soil_moisture_pump_controller_top_defines.svh"

module smpc_datapath
    import smpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_t              req_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    output rsp_t              rsp_data
);

    logic [RAW_W-1:0]  air_reg;
    logic [RAW_W-1:0]  water_reg;
    logic [PCT_W-1:0]  thr_reg;
    logic [TIME_W-1:0] pump_time_reg;

    req_t              item_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [RAW_W-1:0]  div_reg;
    logic [PCT_W-1:0]  sensor_pct_reg [SENSORS];

    logic              run_reg;
    logic              run_next;
    logic [TIME_W-1:0] secs_reg;
    logic [TIME_W-1:0] secs_next;
    logic [RUN_W-1:0]  runs_reg;
    logic [RUN_W-1:0]  runs_next;
    logic              green_reg;
    logic              green_next;
    logic              red_reg;
    logic              red_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              is_sample;
    logic              raw_dry;
    logic              raw_wet;
    logic [RAW_W-1:0]  diff;
    logic [NUM_W-1:0]  shifted;
    logic              any_low;
    logic              started;
    logic              stopped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_reg       <= AIR_RESET;
            water_reg     <= WATER_RESET;
            thr_reg       <= THRESHOLD_RESET;
            pump_time_reg <= PUMP_TIME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AIR:       air_reg       <= cfg_data[RAW_W-1:0];
                CFG_WATER:     water_reg     <= cfg_data[RAW_W-1:0];
                CFG_THRESHOLD: thr_reg       <= cfg_data[PCT_W-1:0];
                CFG_PUMP_TIME: pump_time_reg <= cfg_data[TIME_W-1:0];
                default:       air_reg       <= air_reg;
            endcase
        end
    end

    assign is_sample = (item_reg.action == ACT_SAMPLE);
    assign raw_dry   = (item_reg.raw_value >= air_reg);
    assign raw_wet   = (item_reg.raw_value <= water_reg);
    assign diff      = air_reg - item_reg.raw_value;
    assign shifted   = NUM_W'(div_reg) << cmd.step;

    assign status.is_sample = is_sample;
    assign status.need_div  = !raw_dry && !raw_wet;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req_data;
        end
        if (cmd.mul)
        begin
            rem_reg <= NUM_W'(diff) * NUM_W'(FULL_PERCENT);
            div_reg <= air_reg - water_reg;
            if (raw_dry)
            begin
                pct_reg <= '0;
            end
            else if (raw_wet)
            begin
                pct_reg <= FULL_PERCENT;
            end
            else
            begin
                pct_reg <= '0;
            end
        end
        else if (cmd.div)
        begin
            if (rem_reg >= shifted)
            begin
                rem_reg           <= rem_reg - shifted;
                pct_reg[cmd.step] <= 1'b1;
            end
        end
        if (cmd.eval)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                sensor_pct_reg[i] <= '0;
            end
        end
        else if (cmd.store && (32'(item_reg.sensor_index) < SENSORS))
        begin
            sensor_pct_reg[SIDX_W'(item_reg.sensor_index)] <= pct_reg;
        end
    end

    always_comb
    begin
        any_low = 1'b0;
        for (int i = 0; i < SENSORS; i++)
        begin
            if (sensor_pct_reg[i] < thr_reg)
            begin
                any_low = 1'b1;
            end
        end
    end

    always_comb
    begin
        run_next   = run_reg;
        secs_next  = secs_reg;
        runs_next  = runs_reg;
        green_next = green_reg;
        red_next   = red_reg;
        started    = 1'b0;
        stopped    = 1'b0;

        case (item_reg.action)
            ACT_TICK:
            begin
                if (run_reg && (secs_reg != '1))
                begin
                    secs_next = secs_reg + 1'b1;
                end
            end
            ACT_SAMPLE:
            begin
                if (item_reg.last_sample && !run_reg)
                begin
                    if (any_low)
                    begin
                        run_next   = 1'b1;
                        green_next = 1'b0;
                        red_next   = 1'b1;
                        secs_next  = '0;
                        started    = 1'b1;
                    end
                    else
                    begin
                        green_next = 1'b1;
                        red_next   = 1'b0;
                    end
                end
            end
            ACT_MANUAL:
            begin
                run_next   = 1'b1;
                green_next = 1'b0;
                red_next   = 1'b1;
                secs_next  = '0;
                started    = 1'b1;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase

        if (run_next && (secs_next >= pump_time_reg))
        begin
            run_next   = 1'b0;
            green_next = 1'b1;
            red_next   = 1'b0;
            secs_next  = '0;
            stopped    = 1'b1;
            if (runs_reg != '1)
            begin
                runs_next = runs_reg + 1'b1;
            end
        end

        rsp_next.percent      = is_sample ? pct_reg : '0;
        rsp_next.pump_on      = run_next;
        rsp_next.green_led    = green_next;
        rsp_next.red_led      = red_next;
        rsp_next.pump_started = started;
        rsp_next.pump_stopped = stopped;
        rsp_next.run_count    = runs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            secs_reg  <= '0;
            runs_reg  <= '0;
            green_reg <= 1'b0;
            red_reg   <= 1'b0;
        end
        else if (cmd.eval)
        begin
            run_reg   <= run_next;
            secs_reg  <= secs_next;
            runs_reg  <= runs_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    assign rsp_data = rsp_reg;

    `SMPC_ASSERT_IMPLIES(a_run_leds, run_reg, red_reg && !green_reg, "pump running, no red")
    `SMPC_ASSERT_NEXT(a_pct_range, cmd.div, pct_reg <= FULL_PERCENT, "percent above full scale")
    `SMPC_ASSERT_IMPLIES(a_led_excl, green_reg, !red_reg, "both leds lit")

endmodule

// ===== hw/rtl/smpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpc_ctrl
// Sequencer: accepts a request, steps the datapath, presents the response.
// ----------------------------------------------------------------------------
`include "soil_moisture_pump_controller_top_defines.svh"

module smpc_ctrl
    import smpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (!status.is_sample)
                begin
                    state_next = ST_EVAL;
                end
                else if (status.need_div)
                begin
                    step_next  = LAST_STEP;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_STORE;
                end
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SMPC_ASSERT_NEXT(a_accept_mul, req_valid && req_ready, state_reg == ST_MUL, "no conversion")
    `SMPC_ASSERT_IMPLIES(a_one_item, req_ready, !rsp_valid, "request taken while response pending")
    `SMPC_ASSERT_NEXT(a_eval_done, cmd.eval, rsp_valid, "evaluation not followed by response")

endmodule

// ===== hw/rtl/soil_moisture_pump_controller_top.sv =====
// ----------------------------------------------------------------------------
// soil_moisture_pump_controller_top
// Soil moisture pump controller: sample conversion, round check, pump timing.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       req_valid/req_ready    req_data  (req_t: action, sensor, raw, last)
//  rsp       rsp_valid/rsp_ready    rsp_data  (rsp_t: percent, pump and led state)
//  cfg       cfg_we                 cfg_index, cfg_data
//
//  rsp_valid rises in DONE, reached via MUL and EVAL for a tick, manual start or
//  unused action, via MUL, STORE and EVAL for a sample at a range end, and via MUL,
//  the 7-step divider in DIV, STORE and EVAL for any other sample.
//  One request at a time; req_ready is high only with no response pending.
//  A stalled response holds until rsp_ready; reset restores settings, sensor store and pump state.
// ----------------------------------------------------------------------------
module soil_moisture_pump_controller_top
    import smpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    smpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    smpc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_data  (rsp_data)
    );

endmodule
